/* hdl/rbf_pkg.sv */
// rbf_pkg: shared types, codes and defaults of the burst byte ring buffer
// no dependencies; used by every other file of the block but rbf_if

package rbf_pkg;

  // defaults handed to the top-level parameters
  localparam int unsigned CapacityDef     = 256;
  localparam int unsigned MaxReadBurstDef = 64;

  // read/peek byte count after capping, wide enough for the largest cap
  localparam int unsigned RdLenW = 7;

  // depth of the command queue between front and back
  localparam int unsigned QueueDepth = 2;

  // raw action codes on the input channel
  localparam logic [2:0] ACT_WRITE = 3'd0;
  localparam logic [2:0] ACT_READ  = 3'd1;
  localparam logic [2:0] ACT_PEEK  = 3'd2;
  localparam logic [2:0] ACT_SKIP  = 3'd3;
  localparam logic [2:0] ACT_CLEAR = 3'd4;

  // decoded operation
  typedef enum logic [2:0] {
    OP_WRITE,
    OP_READ,
    OP_PEEK,
    OP_SKIP,
    OP_CLEAR,
    OP_QUERY
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_ROOM  = 2'd1,
    ST_NOTHING  = 2'd2,
    ST_SKIP_FAR = 2'd3
  } status_e;

  // write burst tracking
  typedef enum logic [1:0] {
    B_IDLE,
    B_WRITING,
    B_REJECTING
  } burst_e;

  // back-end sequencer
  typedef enum logic {
    S_IDLE,
    S_RDDAT
  } back_state_e;

  // classified command as queued between front and back
  typedef struct packed {
    op_e               op;
    logic [7:0]        data_byte;
    logic [7:0]        length;
    logic [RdLenW-1:0] rd_len;
  } cmd_t;

endpackage

/* hdl/rbf_if.sv */
// rbf_if: valid/ready channel interfaces for input items and result items
// no dependencies

interface rbf_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] data_byte;
  logic [7:0] length;

  modport source (output valid, action, data_byte, length, input ready);
  modport sink   (input valid, action, data_byte, length, output ready);
endinterface

interface rbf_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       data_valid;
  logic [7:0] read_byte;
  logic       last;
  logic [7:0] readable_count;
  logic [7:0] writable_count;

  modport source (output valid, status, data_valid, read_byte, last,
                  readable_count, writable_count, input ready);
  modport sink   (input valid, status, data_valid, read_byte, last,
                  readable_count, writable_count, output ready);
endinterface

/* hdl/rbf_front.sv */
// rbf_front: accepts input transfers, decodes the action and caps read lengths
// depends on rbf_pkg and rbf_if

module rbf_front #(
  parameter int unsigned MAX_READ_BURST = rbf_pkg::MaxReadBurstDef
) (
  rbf_in_if.sink          in_i,
  input  logic            q_ready_i,
  output logic            q_push_o,
  output rbf_pkg::cmd_t   q_cmd_o
);

  rbf_pkg::op_e op;

  always_comb begin
    unique case (in_i.action)
      rbf_pkg::ACT_WRITE: op = rbf_pkg::OP_WRITE;
      rbf_pkg::ACT_READ:  op = rbf_pkg::OP_READ;
      rbf_pkg::ACT_PEEK:  op = rbf_pkg::OP_PEEK;
      rbf_pkg::ACT_SKIP:  op = rbf_pkg::OP_SKIP;
      rbf_pkg::ACT_CLEAR: op = rbf_pkg::OP_CLEAR;
      default:            op = rbf_pkg::OP_QUERY;
    endcase
  end

  always_comb begin
    q_cmd_o.op        = op;
    q_cmd_o.data_byte = in_i.data_byte;
    q_cmd_o.length    = in_i.length;
    if (in_i.length > 8'(MAX_READ_BURST)) begin
      q_cmd_o.rd_len = rbf_pkg::RdLenW'(MAX_READ_BURST);
    end else begin
      q_cmd_o.rd_len = in_i.length[rbf_pkg::RdLenW-1:0];
    end
  end

  assign in_i.ready = q_ready_i;
  assign q_push_o   = in_i.valid & q_ready_i;

endmodule

/* hdl/rbf_cmd_queue.sv */
// rbf_cmd_queue: short command queue decoupling the front from the back
// depends on rbf_pkg

module rbf_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rbf_pkg::cmd_t cmd_i,
  output logic          ready_o,
  output logic          valid_o,
  output rbf_pkg::cmd_t cmd_o,
  input  logic          pop_i
);

  localparam int unsigned Depth = rbf_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  rbf_pkg::cmd_t   entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign ready_o = (count_q != CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign cmd_o   = entry_q[rd_ptr_q];
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

/* hdl/rbf_back.sv */
// rbf_back: carries out queued commands on the byte store and drives results
// depends on rbf_pkg and rbf_if

module rbf_back #(
  parameter int unsigned CAPACITY       = rbf_pkg::CapacityDef,
  parameter int unsigned MAX_READ_BURST = rbf_pkg::MaxReadBurstDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  rbf_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  rbf_out_if.source     out_o
);

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CmpW = (IdxW > 8) ? IdxW : 8;
  localparam int unsigned RlW  = $clog2(MAX_READ_BURST + 1);
  localparam logic [IdxW-1:0] IdxMask = {IdxW{1'b1}};

  // byte store, contents undefined until written
  logic [7:0]           mem_q [CAPACITY];
  logic [7:0]           rdata_q;
  logic                 mem_we, mem_re;
  logic [IdxW-1:0]      mem_waddr, mem_raddr;

  rbf_pkg::back_state_e state_q, state_d;
  rbf_pkg::burst_e      burst_mode_q, burst_mode_d;
  logic [7:0]           burst_rem_q, burst_rem_d;
  logic [IdxW-1:0]      head_q, head_d;
  logic [IdxW-1:0]      tail_q, tail_d;
  logic [IdxW-1:0]      staged_q, staged_d;
  logic [IdxW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [RlW-1:0]       rd_left_q, rd_left_d;

  logic                 out_valid_q;
  rbf_pkg::status_e     out_status_q, out_status_d;
  logic                 out_dvalid_q, out_dvalid_d;
  logic [7:0]           out_byte_q, out_byte_d;
  logic                 out_last_q, out_last_d;
  logic                 out_load, out_free;

  logic [IdxW-1:0]      held, free;
  logic [CmpW-1:0]      held_ext, free_ext, cnt_ext;
  logic [RlW-1:0]       cnt;

  assign held     = tail_q - head_q;
  assign free     = IdxMask - held;
  assign held_ext = CmpW'(held);
  assign free_ext = CmpW'(free);
  assign out_free = !out_valid_q || out_o.ready;

  // bytes a read or peek will deliver
  assign cnt_ext = (CmpW'(cmd_i.rd_len) > held_ext) ? held_ext : CmpW'(cmd_i.rd_len);
  assign cnt     = RlW'(cnt_ext);

  always_comb begin
    state_d      = state_q;
    burst_mode_d = burst_mode_q;
    burst_rem_d  = burst_rem_q;
    head_d       = head_q;
    tail_d       = tail_q;
    staged_d     = staged_q;
    rd_ptr_d     = rd_ptr_q;
    rd_left_d    = rd_left_q;
    cmd_pop_o    = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = tail_q;
    mem_re       = 1'b0;
    mem_raddr    = rd_ptr_q;
    out_load     = 1'b0;
    out_status_d = rbf_pkg::ST_OK;
    out_dvalid_d = 1'b0;
    out_byte_d   = '0;
    out_last_d   = 1'b1;

    unique case (state_q)
      rbf_pkg::S_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          out_load  = 1'b1;
          // any other action aborts an open burst
          if (cmd_i.op != rbf_pkg::OP_WRITE && burst_mode_q != rbf_pkg::B_IDLE) begin
            burst_mode_d = rbf_pkg::B_IDLE;
            burst_rem_d  = '0;
            staged_d     = tail_q;
          end
          unique case (cmd_i.op)
            rbf_pkg::OP_WRITE: begin
              if (burst_mode_q == rbf_pkg::B_WRITING) begin
                mem_we      = 1'b1;
                mem_waddr   = staged_q;
                staged_d    = staged_q + 1'b1;
                burst_rem_d = burst_rem_q - 1'b1;
                if (burst_rem_q == 8'd1) begin
                  tail_d       = staged_q + 1'b1;
                  burst_mode_d = rbf_pkg::B_IDLE;
                end
              end else if (burst_mode_q == rbf_pkg::B_REJECTING) begin
                burst_rem_d  = burst_rem_q - 1'b1;
                out_status_d = rbf_pkg::ST_NO_ROOM;
                if (burst_rem_q == 8'd1) begin
                  burst_mode_d = rbf_pkg::B_IDLE;
                end
              end else if (cmd_i.length == 8'd0) begin
                out_status_d = rbf_pkg::ST_OK;
              end else if (CmpW'(cmd_i.length) > free_ext) begin
                // burst does not fit: drop it whole
                burst_rem_d  = cmd_i.length - 1'b1;
                out_status_d = rbf_pkg::ST_NO_ROOM;
                if (cmd_i.length != 8'd1) begin
                  burst_mode_d = rbf_pkg::B_REJECTING;
                end
              end else begin
                mem_we      = 1'b1;
                mem_waddr   = tail_q;
                staged_d    = tail_q + 1'b1;
                burst_rem_d = cmd_i.length - 1'b1;
                if (cmd_i.length == 8'd1) begin
                  tail_d = tail_q + 1'b1;
                end else begin
                  burst_mode_d = rbf_pkg::B_WRITING;
                end
              end
            end
            rbf_pkg::OP_READ, rbf_pkg::OP_PEEK: begin
              if (cnt == '0) begin
                out_status_d = rbf_pkg::ST_NOTHING;
              end else begin
                // first byte fetched now, delivered from the read state
                out_load  = 1'b0;
                mem_re    = 1'b1;
                mem_raddr = head_q;
                rd_ptr_d  = head_q + 1'b1;
                rd_left_d = cnt - 1'b1;
                state_d   = rbf_pkg::S_RDDAT;
                if (cmd_i.op == rbf_pkg::OP_READ) begin
                  head_d = head_q + IdxW'(cnt);
                end
              end
            end
            rbf_pkg::OP_SKIP: begin
              if (CmpW'(cmd_i.length) > held_ext) begin
                out_status_d = rbf_pkg::ST_SKIP_FAR;
              end else begin
                head_d = head_q + IdxW'(cmd_i.length);
              end
            end
            rbf_pkg::OP_CLEAR: begin
              head_d   = '0;
              tail_d   = '0;
              staged_d = '0;
            end
            default: begin
              out_status_d = rbf_pkg::ST_OK;
            end
          endcase
        end
      end
      rbf_pkg::S_RDDAT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_dvalid_d = 1'b1;
          out_byte_d   = rdata_q;
          out_last_d   = (rd_left_q == '0);
          if (rd_left_q != '0) begin
            mem_re    = 1'b1;
            mem_raddr = rd_ptr_q;
            rd_ptr_d  = rd_ptr_q + 1'b1;
            rd_left_d = rd_left_q - 1'b1;
          end else begin
            state_d = rbf_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_d = rbf_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= rbf_pkg::S_IDLE;
      burst_mode_q <= rbf_pkg::B_IDLE;
      burst_rem_q  <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      staged_q     <= '0;
      rd_ptr_q     <= '0;
      rd_left_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      burst_mode_q <= burst_mode_d;
      burst_rem_q  <= burst_rem_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      staged_q     <= staged_d;
      rd_ptr_q     <= rd_ptr_d;
      rd_left_q    <= rd_left_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= out_status_d;
      out_dvalid_q <= out_dvalid_d;
      out_byte_q   <= out_byte_d;
      out_last_q   <= out_last_d;
    end
  end

  // single-port style store: one write or one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= cmd_i.data_byte;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // counts follow the committed indices, which hold while a result waits
  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_status_q;
  assign out_o.data_valid     = out_dvalid_q;
  assign out_o.read_byte      = out_byte_q;
  assign out_o.last           = out_last_q;
  assign out_o.readable_count = (held_ext > CmpW'(255)) ? 8'hFF : held_ext[7:0];
  assign out_o.writable_count = (free_ext > CmpW'(255)) ? 8'hFF : free_ext[7:0];

`ifndef SYNTHESIS
  a_idle_staged_eq_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (burst_mode_q == rbf_pkg::B_IDLE) |-> (staged_q == tail_q))
    else $error("staged tail differs from tail outside a burst");

  a_burst_has_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (burst_mode_q != rbf_pkg::B_IDLE) |-> (burst_rem_q != 8'd0))
    else $error("open burst with nothing remaining");

  a_read_no_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rbf_pkg::S_RDDAT) |-> (burst_mode_q == rbf_pkg::B_IDLE))
    else $error("read sequence running while a burst is open");

  a_read_left_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rbf_pkg::S_RDDAT) |-> (rd_left_q < RlW'(MAX_READ_BURST)))
    else $error("read byte count beyond the read cap");
`endif

endmodule

/* hdl/ring_byte_fifo_burst.sv */
// ring_byte_fifo_burst: a byte ring buffer of CAPACITY entries (CAPACITY-1 usable) with
// all-or-nothing write bursts. Each input transfer carries an action: write byte, read,
// peek, skip, clear or query. The first write of a burst gives its length; a burst that
// fits the free space is staged and the tail committed after its last byte, otherwise
// every byte of it is answered with a no-room status and dropped. Any other action in
// the middle of a burst aborts it first. Read and peek deliver up to length bytes (at
// most MAX_READ_BURST) as one result transfer per byte, the last flagged; every other
// action gives exactly one result. Each result carries the readable and writable counts
// after its action, saturated at 255. Flow: a command passes a two-entry queue to the
// back end, which carries out a write, skip, clear or query from its idle state; a read
// or peek that finds bytes first makes the registered read of the single-port byte
// store, with bytes then streamed one per cycle while the sink is ready. The store
// needs no clearing pass after reset: only committed bytes are ever read back.
// depends on rbf_pkg, rbf_if, rbf_front, rbf_cmd_queue and rbf_back

module ring_byte_fifo_burst #(
  parameter int unsigned CAPACITY       = rbf_pkg::CapacityDef,     // power of two
  parameter int unsigned MAX_READ_BURST = rbf_pkg::MaxReadBurstDef  // 1 to 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rbf_in_if.sink    in_i,
  rbf_out_if.source out_o
);

  // front to queue
  logic          q_ready;
  logic          q_push;
  rbf_pkg::cmd_t q_cmd_in;

  // queue to back
  logic          q_valid;
  logic          q_pop;
  rbf_pkg::cmd_t q_cmd_out;

  // decode and read-length capping on the input transfer
  rbf_front #(
    .MAX_READ_BURST (MAX_READ_BURST)
  ) u_front (
    .in_i      (in_i),
    .q_ready_i (q_ready),
    .q_push_o  (q_push),
    .q_cmd_o   (q_cmd_in)
  );

  // lets the input side keep accepting while the back end streams bytes
  rbf_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_cmd_in),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .cmd_o   (q_cmd_out),
    .pop_i   (q_pop)
  );

  // indices, burst tracking, byte store and the result register
  rbf_back #(
    .CAPACITY       (CAPACITY),
    .MAX_READ_BURST (MAX_READ_BURST)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd_out),
    .cmd_pop_o   (q_pop),
    .out_o       (out_o)
  );

endmodule

/* bench/ring_byte_fifo_burst_test.sv */
// ring_byte_fifo_burst_test: self-checking bench for the burst byte ring buffer
// holds a result scoreboard with its own ring predictor, plus stimulus tasks and a result sink
// depends on rbf_pkg, rbf_if and the ring_byte_fifo_burst top level

`timescale 1ns / 100ps

import rbf_pkg::*;

typedef struct {
  status_e    status;
  logic       data_valid;
  logic [7:0] read_byte;
  logic       last;
  logic [7:0] readable;
  logic [7:0] writable;
} fifo_result_t;

// predicts every result of the ring and checks what the block delivers
class fifo_result_board;
  logic [7:0]   byte_mem [256];
  logic [7:0]   head;
  logic [7:0]   tail;
  logic [7:0]   staged;
  logic [7:0]   burst_left;
  burst_e       burst_state;
  fifo_result_t step_results [$];
  fifo_result_t pending_results [$];
  int unsigned  mismatches;
  int unsigned  results_seen;
  int unsigned  rejected_writes;
  int unsigned  full_reads;
  int unsigned  peak_held;

  function new();
    foreach (byte_mem[i]) byte_mem[i] = 8'h00;
    head            = 8'd0;
    tail            = 8'd0;
    staged          = 8'd0;
    burst_left      = 8'd0;
    burst_state     = B_IDLE;
    mismatches      = 0;
    results_seen    = 0;
    rejected_writes = 0;
    full_reads      = 0;
    peak_held       = 0;
  endfunction

  function logic [7:0] held();
    return tail - head;
  endfunction

  function int unsigned outstanding();
    return pending_results.size();
  endfunction

  function void add_result(status_e st, logic dv, logic [7:0] b);
    fifo_result_t r;
    r.status     = st;
    r.data_valid = dv;
    r.read_byte  = b;
    r.last       = 1'b0;
    r.readable   = 8'd0;
    r.writable   = 8'd0;
    step_results.push_back(r);
  endfunction

  // advance the ring by one accepted input transfer
  function void note_item(logic [2:0] act, logic [7:0] db, logic [7:0] len);
    logic [7:0]  cnt;
    logic [7:0]  p;
    logic [7:0]  rc;
    fifo_result_t r;
    step_results.delete();
    // anything but a write aborts an open burst
    if (act != ACT_WRITE && burst_state != B_IDLE) begin
      burst_state = B_IDLE;
      burst_left  = 8'd0;
      staged      = tail;
    end
    case (act)
      ACT_WRITE: begin
        if (burst_state == B_WRITING) begin
          byte_mem[staged] = db;
          staged           = staged + 8'd1;
          burst_left       = burst_left - 8'd1;
          if (burst_left == 8'd0) begin
            tail        = staged;
            burst_state = B_IDLE;
          end
          add_result(ST_OK, 1'b0, 8'h00);
        end else if (burst_state == B_REJECTING) begin
          burst_left = burst_left - 8'd1;
          if (burst_left == 8'd0) burst_state = B_IDLE;
          rejected_writes++;
          add_result(ST_NO_ROOM, 1'b0, 8'h00);
        end else if (len == 8'd0) begin
          add_result(ST_OK, 1'b0, 8'h00);
        end else if (len > 8'd255 - held()) begin
          burst_left = len - 8'd1;
          if (burst_left != 8'd0) burst_state = B_REJECTING;
          rejected_writes++;
          add_result(ST_NO_ROOM, 1'b0, 8'h00);
        end else begin
          byte_mem[tail] = db;
          staged         = tail + 8'd1;
          burst_left     = len - 8'd1;
          if (burst_left == 8'd0) tail = staged;
          else burst_state = B_WRITING;
          add_result(ST_OK, 1'b0, 8'h00);
        end
      end
      ACT_READ, ACT_PEEK: begin
        cnt = len;
        if (cnt > MaxReadBurstDef) cnt = MaxReadBurstDef;
        if (cnt > held()) cnt = held();
        if (cnt == MaxReadBurstDef) full_reads++;
        if (cnt == 8'd0) begin
          add_result(ST_NOTHING, 1'b0, 8'h00);
        end else begin
          p = head;
          repeat (cnt) begin
            add_result(ST_OK, 1'b1, byte_mem[p]);
            p = p + 8'd1;
          end
          if (act == ACT_READ) head = p;
        end
      end
      ACT_SKIP: begin
        if (len > held()) begin
          add_result(ST_SKIP_FAR, 1'b0, 8'h00);
        end else begin
          head = head + len;
          add_result(ST_OK, 1'b0, 8'h00);
        end
      end
      ACT_CLEAR: begin
        head   = 8'd0;
        tail   = 8'd0;
        staged = 8'd0;
        add_result(ST_OK, 1'b0, 8'h00);
      end
      default: add_result(ST_OK, 1'b0, 8'h00);
    endcase
    rc = held();
    if (rc > peak_held) peak_held = rc;
    foreach (step_results[i]) begin
      r          = step_results[i];
      r.readable = rc;
      r.writable = 8'd255 - rc;
      r.last     = (i == step_results.size() - 1);
      pending_results.push_back(r);
    end
  endfunction

  function void compare_result(logic [1:0] st, logic dv, logic [7:0] rb, logic lst,
                               logic [7:0] rc, logic [7:0] wc);
    fifo_result_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result %0d: st=%0d dv=%b byte=%02h last=%b rc=%0d wc=%0d",
                 results_seen, st, dv, rb, lst, rc, wc);
      return;
    end
    want = pending_results.pop_front();
    if (want.status !== st || want.data_valid !== dv || want.read_byte !== rb ||
        want.last !== lst || want.readable !== rc || want.writable !== wc) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result %0d mismatch: expected st=%0d dv=%b byte=%02h last=%b rc=%0d wc=%0d",
                 results_seen, want.status, want.data_valid, want.read_byte, want.last,
                 want.readable, want.writable);
        $display("result %0d mismatch: actual   st=%0d dv=%b byte=%02h last=%b rc=%0d wc=%0d",
                 results_seen, st, dv, rb, lst, rc, wc);
      end
    end
  endfunction
endclass

module ring_byte_fifo_burst_test;

  // action codes the package leaves unnamed: query and the two spare codes
  localparam logic [2:0] ACT_QUERY   = 3'd5;
  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;

  localparam int unsigned RANDOM_ITEMS = 470;
  localparam int unsigned HOLD_AT      = 200;     // input transfer that starts the long hold
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 100;     // longer than a full-length read
  localparam int unsigned CYCLE_LIMIT  = 1500000;

  logic clk_i;
  logic rst_ni;

  rbf_in_if  in_bus ();
  rbf_out_if out_bus ();

  ring_byte_fifo_burst u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  fifo_result_board board = new();

  int unsigned items_sent = 0;
  int unsigned cycles     = 0;
  bit          send_calm  = 1'b0;   // stretch with no gaps on the input side
  bit          sink_calm  = 1'b0;   // stretch with no stalls on the output side
  bit          hold_req   = 1'b0;   // asks the sink for one long hold-off
  bit          draining   = 1'b0;
  bit          fill_phase = 1'b1;   // random part alternates filling and draining the ring

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // gap of idle cycles ahead of a transfer, none during a calm stretch
  function automatic int unsigned draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 10);
  endfunction

  // offer one input item and wait for its transfer; valid stays high across
  // back-to-back items so it is never lowered and raised in one step
  task automatic send_item(input logic [2:0] act, input logic [7:0] db,
                           input logic [7:0] len);
    int unsigned gap;
    gap = draw_gap(send_calm);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid     <= 1'b1;
    in_bus.action    <= act;
    in_bus.data_byte <= db;
    in_bus.length    <= len;
    do @(posedge clk_i); while (in_bus.ready !== 1'b1);
    board.note_item(act, db, len);
    items_sent++;
    if (items_sent % 40 == 0) send_calm = ($urandom_range(0, 3) == 0);
    if (items_sent == HOLD_AT) hold_req = 1'b1;
  endtask

  // a burst header of the given length followed by more bytes, n_items in all; the
  // length field of the follow-on bytes carries noise, which the block ignores
  task automatic write_burst(input logic [7:0] len, input int unsigned n_items);
    send_item(ACT_WRITE, 8'($urandom_range(0, 255)), len);
    for (int unsigned i = 1; i < n_items; i++)
      send_item(ACT_WRITE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  // one well-formed sequence, or now and then a broken burst
  task automatic random_sequence();
    int unsigned r;
    int unsigned len;
    int unsigned held_now;
    int unsigned free_now;
    held_now = board.held();
    free_now = 255 - held_now;
    if (fill_phase && held_now >= 245) fill_phase = 1'b0;
    else if (!fill_phase && held_now < 16) fill_phase = 1'b1;
    r = $urandom_range(0, 99);
    if (r < (fill_phase ? 65 : 25)) begin
      case ($urandom_range(0, 7))
        0:       len = (free_now != 0 && free_now <= 64) ? free_now : $urandom_range(1, 32);
        1:       len = 0;
        default: len = $urandom_range(1, 24);
      endcase
      // an exact fit leaves the ring full, anything beyond free space is refused
      write_burst(8'(len), (len == 0) ? 1 : len);
    end else if (r < 80) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 70);
      send_item(($urandom_range(0, 1) == 0) ? ACT_READ : ACT_PEEK,
                8'($urandom_range(0, 255)), 8'(len));
    end else if (r < 88) begin
      len = ($urandom_range(0, 1) == 0) ? $urandom_range(0, held_now) : $urandom_range(0, 255);
      send_item(ACT_SKIP, 8'($urandom_range(0, 255)), 8'(len));
    end else if (r < 92) begin
      send_item(3'($urandom_range(5, 7)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
    end else if (r < 94) begin
      send_item(ACT_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    end else begin
      // burst cut short, then aborted by some other action
      len = $urandom_range(2, 255);
      write_burst(8'(len), $urandom_range(1, (len - 1 < 12) ? len - 1 : 12));
      send_item(3'($urandom_range(1, 7)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 8)));
    end
  endtask

  // result sink: random stalls, one long hold-off on request
  initial begin : result_sink
    int unsigned stall;
    int unsigned taken;
    taken = 0;
    out_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      stall = draw_gap(sink_calm || draining);
      if (stall != 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (out_bus.valid !== 1'b1);
      board.compare_result(out_bus.status, out_bus.data_valid, out_bus.read_byte,
                           out_bus.last, out_bus.readable_count, out_bus.writable_count);
      taken++;
      if (taken % 40 == 0) sink_calm = ($urandom_range(0, 3) == 0);
    end
  end

  // watchdog on the whole run
  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles, board.outstanding());
    $display("ring_byte_fifo_burst_test: FAIL");
    $finish;
  end

  initial begin : stimulus
    int unsigned directed_count;
    in_bus.valid     <= 1'b0;
    in_bus.action    <= ACT_QUERY;
    in_bus.data_byte <= 8'h00;
    in_bus.length    <= 8'h00;
    rst_ni           <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed part: empty ring corner cases first
    send_item(ACT_QUERY, 8'h00, 8'h00);
    send_item(ACT_READ,  8'hFF, 8'd255);    // read from empty, nothing read
    send_item(ACT_PEEK,  8'h00, 8'd0);      // peek of zero bytes
    send_item(ACT_SKIP,  8'h00, 8'd0);      // skip of zero is fine
    send_item(ACT_SKIP,  8'hFF, 8'd255);    // skip beyond readable
    send_item(ACT_WRITE, 8'h55, 8'd0);      // zero-length burst stores nothing
    send_item(ACT_WRITE, 8'hFF, 8'd1);      // single-byte burst
    send_item(ACT_WRITE, 8'h00, 8'd3);      // three-byte burst
    send_item(ACT_WRITE, 8'hA5, 8'd200);    // length ignored inside a burst
    send_item(ACT_WRITE, 8'h5A, 8'd0);      // commits the tail
    send_item(ACT_WRITE, 8'h11, 8'd255);    // too long, refused
    send_item(ACT_WRITE, 8'h22, 8'd7);      // dropped byte of the refused burst
    send_item(ACT_PEEK,  8'h00, 8'd2);      // aborts the refused burst, then peeks
    send_item(ACT_READ,  8'h00, 8'd255);    // capped by what is held
    send_item(ACT_WRITE, 8'h80, 8'd2);      // staged byte
    send_item(ACT_READ,  8'h00, 8'd1);      // aborts, staged byte discarded, nothing read
    send_item(ACT_WRITE, 8'h7F, 8'd2);
    send_item(ACT_WRITE, 8'h01, 8'd0);
    send_item(ACT_SKIP,  8'h00, 8'd3);      // one past readable
    send_item(ACT_SKIP,  8'h00, 8'd2);      // exactly readable
    send_item(ACT_SPARE_6, 8'hFF, 8'hFF);   // spare codes behave as query
    send_item(ACT_SPARE_7, 8'h00, 8'h00);
    send_item(ACT_WRITE, 8'h3C, 8'd1);
    send_item(ACT_CLEAR, 8'h00, 8'h00);
    send_item(ACT_QUERY, 8'h00, 8'h00);
    directed_count = items_sent;

    // random part, well-formed sequences with some noise
    while (items_sent < directed_count + RANDOM_ITEMS) random_sequence();
    in_bus.valid <= 1'b0;

    // let the sink empty the block, then watch for stray results
    draining = 1'b1;
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d input transfers and %0d result transfers in %0d cycles",
             items_sent, board.results_seen, cycles);
    $display("refused writes %0d, full-length reads %0d, peak fill %0d of 255",
             board.rejected_writes, board.full_reads, board.peak_held);
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("ring_byte_fifo_burst_test: PASS");
    end else begin
      $display("%0d mismatches, %0d results never delivered",
               board.mismatches, board.outstanding());
      $display("ring_byte_fifo_burst_test: FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/rbf_pkg.sv
hdl/rbf_if.sv
hdl/rbf_front.sv
hdl/rbf_cmd_queue.sv
hdl/rbf_back.sv
hdl/ring_byte_fifo_burst.sv
bench/ring_byte_fifo_burst_test.sv
